### rtl/core/binary_max_heap_queue_assert.svh
// Assertion macros used by the heap queue checker.
`ifndef BINARY_MAX_HEAP_QUEUE_ASSERT_SVH
`define BINARY_MAX_HEAP_QUEUE_ASSERT_SVH
// Assert a property on the rising clock, held off during reset.
`define BHQ_ASSERT(lbl, ck, rn, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) else $error(msg);
// Assert that a condition implies a consequence in the same cycle.
`define BHQ_ASSERT_IMPLY(lbl, ck, rn, cond, cons, msg) \
	`BHQ_ASSERT(lbl, ck, rn, (cond) |-> (cons), msg)
`endif

### rtl/core/bhq_pkg.sv
// Shared command and status types of the heap queue.
`timescale 1ns / 1ps
package bhq_pkg;
	typedef struct packed {
		logic accept;
		logic set_err;
		logic ins_init;
		logic pop_init;
		logic rd_last;
		logic rd_parent;
		logic rd_left;
		logic rd_right;
		logic wr_cur;
		logic wr_parent;
		logic wr_child;
		logic up_move;
		logic take_left;
		logic take_right;
		logic dn_move;
	} cmd_t;

	typedef struct packed {
		logic is_pop;
		logic empty;
		logic full;
		logic at_root;
		logic leaf;
		logic has_right;
		logic parent_less;
		logic right_more;
		logic cur_greater;
	} status_t;
endpackage

### rtl/core/bhq_ctrl.sv
// Sequencer for the heap queue sift walks.
`timescale 1ns / 1ps
module bhq_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  bhq_pkg::status_t st,
	output bhq_pkg::cmd_t    cmd,
	output logic             busy,
	output logic             done
);
	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_CHECK   = 4'd1;
	localparam logic [3:0] S_UP_TEST = 4'd2;
	localparam logic [3:0] S_UP_CMP  = 4'd3;
	localparam logic [3:0] S_POP_LST = 4'd4;
	localparam logic [3:0] S_DN_TEST = 4'd5;
	localparam logic [3:0] S_DN_L    = 4'd6;
	localparam logic [3:0] S_DN_R    = 4'd7;
	localparam logic [3:0] S_DN_CMP  = 4'd8;
	localparam logic [3:0] S_FINISH  = 4'd9;

	logic [3:0] state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.accept = 1'b1;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (st.is_pop) begin
					if (st.empty) begin
						cmd.set_err = 1'b1;
						state_d = S_FINISH;
					end else begin
						cmd.rd_last = 1'b1;
						state_d = S_POP_LST;
					end
				end else if (st.full) begin
					cmd.set_err = 1'b1;
					state_d = S_FINISH;
				end else begin
					cmd.ins_init = 1'b1;
					state_d = S_UP_TEST;
				end
			end
			S_UP_TEST: begin
				if (st.at_root) begin
					cmd.wr_cur = 1'b1;
					state_d = S_FINISH;
				end else begin
					cmd.rd_parent = 1'b1;
					state_d = S_UP_CMP;
				end
			end
			S_UP_CMP: begin
				if (st.parent_less) begin
					cmd.wr_parent = 1'b1;
					cmd.up_move = 1'b1;
					state_d = S_UP_TEST;
				end else begin
					cmd.wr_cur = 1'b1;
					state_d = S_FINISH;
				end
			end
			S_POP_LST: begin
				cmd.pop_init = 1'b1;
				state_d = S_DN_TEST;
			end
			S_DN_TEST: begin
				if (st.empty) begin
					state_d = S_FINISH;
				end else if (st.leaf) begin
					cmd.wr_cur = 1'b1;
					state_d = S_FINISH;
				end else begin
					cmd.rd_left = 1'b1;
					state_d = S_DN_L;
				end
			end
			S_DN_L: begin
				cmd.take_left = 1'b1;
				if (st.has_right) begin
					cmd.rd_right = 1'b1;
					state_d = S_DN_R;
				end else begin
					state_d = S_DN_CMP;
				end
			end
			S_DN_R: begin
				cmd.take_right = st.right_more;
				state_d = S_DN_CMP;
			end
			S_DN_CMP: begin
				if (st.cur_greater) begin
					cmd.wr_cur = 1'b1;
					state_d = S_FINISH;
				end else begin
					cmd.wr_child = 1'b1;
					cmd.dn_move = 1'b1;
					state_d = S_DN_TEST;
				end
			end
			S_FINISH: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_FINISH);
endmodule

### rtl/core/bhq_dp.sv
// Heap store, walk position and entry registers of the heap queue.
`timescale 1ns / 1ps
module bhq_dp #(
	parameter int CAPACITY      = 1024,
	parameter int TAG_BITS      = 16,
	parameter int PRIORITY_BITS = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  bhq_pkg::cmd_t                   cmd,
	output bhq_pkg::status_t                st,
	input  logic                            operation,
	input  logic        [TAG_BITS-1:0]      entry_tag,
	input  logic signed [PRIORITY_BITS-1:0] entry_priority,
	output logic        [TAG_BITS-1:0]      top_tag,
	output logic signed [PRIORITY_BITS-1:0] top_priority,
	output logic [$clog2(CAPACITY+1)-1:0]   entry_count,
	output logic                            queue_empty,
	output logic                            op_error
);
	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int EW = TAG_BITS + PRIORITY_BITS;

	logic [EW-1:0] mem [CAPACITY];
	logic [EW-1:0] rdata_q, cur_q, child_q, wdata;
	logic [CW-1:0] n_q, pos_q, c_q, c2;
	logic          op_q, err_q;
	logic [AW-1:0] raddr, waddr;
	logic          rd_en, we;
	logic [TAG_BITS-1:0]      root_tag_q;
	logic [PRIORITY_BITS-1:0] root_prio_q;

	function automatic logic signed [PRIORITY_BITS-1:0] prio_of(input logic [EW-1:0] e);
		return $signed(e[PRIORITY_BITS-1:0]);
	endfunction

	assign c2 = {pos_q[CW-2:0], 1'b0};

	always_comb begin
		raddr = '0;
		if (cmd.rd_last) raddr = AW'(n_q - 1'b1);
		else if (cmd.rd_parent) raddr = AW'((pos_q >> 1) - 1'b1);
		else if (cmd.rd_left) raddr = AW'(c2 - 1'b1);
		else if (cmd.rd_right) raddr = AW'(c2);
	end
	assign rd_en = cmd.rd_last | cmd.rd_parent | cmd.rd_left | cmd.rd_right;
	assign we    = cmd.wr_cur | cmd.wr_parent | cmd.wr_child;
	assign waddr = AW'(pos_q - 1'b1);
	assign wdata = cmd.wr_parent ? rdata_q : (cmd.wr_child ? child_q : cur_q);

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (rd_en) rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) cur_q <= {entry_tag, entry_priority};
		else if (cmd.pop_init) cur_q <= rdata_q;
		if (cmd.take_left) begin
			child_q <= rdata_q;
			c_q <= c2;
		end else if (cmd.take_right) begin
			child_q <= rdata_q;
			c_q <= c_q + 1'b1;
		end
		if (cmd.ins_init) pos_q <= n_q + 1'b1;
		else if (cmd.pop_init) pos_q <= CW'(1);
		else if (cmd.up_move) pos_q <= pos_q >> 1;
		else if (cmd.dn_move) pos_q <= c_q;
		if (we && waddr == '0) begin
			root_tag_q  <= wdata[EW-1:PRIORITY_BITS];
			root_prio_q <= wdata[PRIORITY_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q   <= '0;
			op_q  <= 1'b0;
			err_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				op_q  <= operation;
				err_q <= 1'b0;
			end
			if (cmd.set_err) err_q <= 1'b1;
			if (cmd.ins_init) n_q <= n_q + 1'b1;
			else if (cmd.pop_init) n_q <= n_q - 1'b1;
		end
	end

	always_comb begin
		st.is_pop      = op_q;
		st.empty       = (n_q == '0);
		st.full        = (n_q == CW'(CAPACITY));
		st.at_root     = (pos_q == CW'(1));
		st.leaf        = (pos_q > (n_q >> 1));
		st.has_right   = (c2 < n_q);
		st.parent_less = (prio_of(rdata_q) < prio_of(cur_q));
		st.right_more  = (prio_of(child_q) < prio_of(rdata_q));
		st.cur_greater = (prio_of(cur_q) > prio_of(child_q));
	end

	assign queue_empty  = (n_q == '0);
	assign top_tag      = queue_empty ? '0 : root_tag_q;
	assign top_priority = queue_empty ? '0 : $signed(root_prio_q);
	assign entry_count  = n_q;
	assign op_error     = err_q;
endmodule

### rtl/core/binary_max_heap_queue.sv
// Top level of the bounded binary max-heap priority queue.
`timescale 1ns / 1ps
// Bounded max-heap priority queue. Raise start while busy is low to hand in a
// request: operation 0 inserts {entry_tag, entry_priority}, operation 1 pops
// the highest-priority entry. Exactly one result follows each request, shown
// for one cycle with done high: root tag and priority (zero when empty), the
// entry count, queue_empty, and op_error for a pop on an empty queue or an
// insert on a full one (the request is then dropped). The receiver cannot
// stall, so sample the result whenever done is high. Cycle cost is set by the
// single-port heap memory walked one level at a time. A refused request goes
// straight to its result; an insert climbs one level per step until it
// reaches the root or meets a parent that is not lower; a pop moves the last
// entry to the root and sinks it toward the larger child until it reaches a
// leaf or is greater than that child (a level without a right child skips
// the right-child read). busy drops in the cycle after done, when the next
// request can be accepted.
// Ties follow strict compares: an inserted entry stops below an equal
// parent, and a sinking entry yields to an equal child.
module binary_max_heap_queue #(
	parameter int CAPACITY      = 1024,
	parameter int TAG_BITS      = 16,
	parameter int PRIORITY_BITS = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic                            operation,
	input  logic        [TAG_BITS-1:0]      entry_tag,
	input  logic signed [PRIORITY_BITS-1:0] entry_priority,
	output logic                            done,
	output logic        [TAG_BITS-1:0]      top_tag,
	output logic signed [PRIORITY_BITS-1:0] top_priority,
	output logic [$clog2(CAPACITY+1)-1:0]   entry_count,
	output logic                            queue_empty,
	output logic                            op_error
);
	bhq_pkg::cmd_t    cmd;
	bhq_pkg::status_t st;

	// Sequence each request through check, any sift walk and result cycle.
	bhq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.st     (st),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// Hold the heap store, the root copy and the walk registers.
	bhq_dp #(
		.CAPACITY      (CAPACITY),
		.TAG_BITS      (TAG_BITS),
		.PRIORITY_BITS (PRIORITY_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.st             (st),
		.operation      (operation),
		.entry_tag      (entry_tag),
		.entry_priority (entry_priority),
		.top_tag        (top_tag),
		.top_priority   (top_priority),
		.entry_count    (entry_count),
		.queue_empty    (queue_empty),
		.op_error       (op_error)
	);
endmodule

### rtl/core/bhq_checker.sv
// Port-level checker of the heap queue and its bind.
`timescale 1ns / 1ps
`include "binary_max_heap_queue_assert.svh"
module bhq_checker #(
	parameter int CAPACITY      = 1024,
	parameter int TAG_BITS      = 16,
	parameter int PRIORITY_BITS = 32
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              start,
	input logic                              busy,
	input logic                              done,
	input logic [TAG_BITS-1:0]               top_tag,
	input logic signed [PRIORITY_BITS-1:0]   top_priority,
	input logic [$clog2(CAPACITY+1)-1:0]     entry_count,
	input logic                              queue_empty
);
	`BHQ_ASSERT_IMPLY(a_accept_busy, clk, arst_n, start && !busy, ##1 busy, "accepted request did not raise busy")
	`BHQ_ASSERT_IMPLY(a_done_pulse, clk, arst_n, done, ##1 !done, "result strobe longer than one cycle")
	`BHQ_ASSERT(a_empty_count, clk, arst_n, queue_empty == (entry_count == '0), "empty flag disagrees with count")
	`BHQ_ASSERT_IMPLY(a_empty_top, clk, arst_n, done && queue_empty, top_tag == '0 && top_priority == '0, "top fields nonzero on empty queue")
	`BHQ_ASSERT(a_count_max, clk, arst_n, entry_count <= ($clog2(CAPACITY+1))'(CAPACITY), "count above capacity")
endmodule

bind binary_max_heap_queue bhq_checker #(
	.CAPACITY      (CAPACITY),
	.TAG_BITS      (TAG_BITS),
	.PRIORITY_BITS (PRIORITY_BITS)
) u_bhq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.top_tag      (top_tag),
	.top_priority (top_priority),
	.entry_count  (entry_count),
	.queue_empty  (queue_empty)
);
